/* hw/rtl/lkc_pkg.sv */
`default_nettype none

package lkc_pkg;

    localparam int ENTRIES_DEF  = 64;
    localparam int KEY_BITS_DEF = 32;
    localparam int CAP_RESET    = 64;

    localparam int MODE_W  = 1;
    localparam int KEY_W   = 32;
    localparam int SLOT_W  = 6;
    localparam int OCC_W   = 7;
    localparam int TOTAL_W = 32;
    localparam int CFG_W   = 7;

    localparam logic [MODE_W-1:0] MODE_ACCESS = 1'b0;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SCAN   = 6'b000010,
        ST_DECIDE = 6'b000100,
        ST_UPDATE = 6'b001000,
        ST_WRITE  = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    typedef struct packed {
        logic hit_inc;
        logic miss_inc;
    } stats_upd_t;

endpackage

`default_nettype wire

/* hw/rtl/lkc_in_if.sv */
`default_nettype none

interface lkc_in_if import lkc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key;

    modport source (output valid, output mode, output key, input ready);
    modport sink (input valid, input mode, input key, output ready);
endinterface

`default_nettype wire

/* hw/rtl/lkc_out_if.sv */
`default_nettype none

interface lkc_out_if import lkc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic               evicted;
    logic [KEY_W-1:0]   evicted_key;
    logic [OCC_W-1:0]   occupancy;
    logic [TOTAL_W-1:0] hit_total;
    logic [TOTAL_W-1:0] miss_total;

    modport source (output valid, output hit, output slot, output evicted,
                    output evicted_key, output occupancy, output hit_total,
                    output miss_total, input ready);
    modport sink (input valid, input hit, input slot, input evicted,
                  input evicted_key, input occupancy, input hit_total,
                  input miss_total, output ready);
endinterface

`default_nettype wire

/* hw/rtl/lkc_ram.sv */
`default_nettype none

module lkc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/lkc_stats.sv */
`default_nettype none

module lkc_stats import lkc_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire stats_upd_t         upd,
    output logic [TOTAL_W-1:0]      hit_total,
    output logic [TOTAL_W-1:0]      miss_total
);

    logic [TOTAL_W-1:0] hit_reg;
    logic [TOTAL_W-1:0] miss_reg;

    // Both counters stop at all ones.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg  <= '0;
            miss_reg <= '0;
        end
        else
        begin
            if (upd.hit_inc && (hit_reg != '1))
            begin
                hit_reg <= hit_reg + TOTAL_W'(1);
            end
            if (upd.miss_inc && (miss_reg != '1))
            begin
                miss_reg <= miss_reg + TOTAL_W'(1);
            end
        end
    end

    assign hit_total  = hit_reg;
    assign miss_total = miss_reg;

endmodule

`default_nettype wire

/* hw/rtl/lru_key_cache_core.sv */
// Fully associative LRU cache of key tags.
// A request on req carries mode and key. Mode access looks the key up: a hit
// makes the entry most recent, a miss inserts it as most recent and evicts
// the least recent entry once occupancy has reached the capacity. Mode clear
// invalidates every entry; the hit and miss totals are kept.
// Each request gives one response on rsp with hit, slot, eviction, evicted
// key, occupancy and the saturating totals.
// Tags and recency ranks live in one RAM with a registered read port. An
// access request sweeps the RAM twice, once to search and once to age the
// ranks, then writes the target entry; a clear needs no sweep. The block
// returns to idle, ready for the next request, in the same cycle as its
// response becomes valid.
// One request is worked at a time; req.ready is high while the block waits
// for a request, also while a finished response still waits on rsp.
// When the receiver stalls, the next response waits in its final state.
// The capacity register is written through cfg_we/cfg_data, only while the
// cache is empty; 0 reads as 1 and values above ENTRIES saturate.
// Reset empties the cache, clears the totals and sets capacity to 64
// (limited to ENTRIES). The tag RAM needs no clearing pass.
`default_nettype none

module lru_key_cache_core import lkc_pkg::*; #(
    parameter int ENTRIES  = ENTRIES_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [CFG_W-1:0] cfg_data,
    lkc_in_if.sink                req,
    lkc_out_if.source             rsp
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int SWP_W = IDX_W + 1;
    localparam int RAM_W = KEY_BITS + IDX_W;

    state_t               state_reg;
    logic [ENTRIES-1:0]   valid_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     cap_reg;
    logic [SWP_W-1:0]     issue_reg;
    logic                 pend_reg;
    logic [IDX_W-1:0]     pend_addr_reg;
    logic [KEY_BITS-1:0]  key_reg;
    logic                 hit_found_reg;
    logic [IDX_W-1:0]     hit_slot_reg;
    logic [IDX_W-1:0]     hit_rank_reg;
    logic                 free_found_reg;
    logic [IDX_W-1:0]     free_slot_reg;
    logic                 ev_found_reg;
    logic [IDX_W-1:0]     ev_slot_reg;
    logic [KEY_BITS-1:0]  ev_key_reg;
    logic                 hit_reg;
    logic                 evict_reg;
    logic [IDX_W-1:0]     tgt_reg;
    logic                 out_valid_reg;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [RAM_W-1:0]     ram_wdata;
    logic                 ram_re;
    logic [RAM_W-1:0]     ram_rdata;
    logic [KEY_BITS-1:0]  rd_tag;
    logic [IDX_W-1:0]     rd_rank;
    logic                 rd_valid;
    logic                 sweep_last;
    logic [IDX_W-1:0]     oldest_rank;
    logic                 evict_now;
    logic                 out_load;
    logic                 accept;
    logic [8:0]           cap_raw;
    logic [CNT_W-1:0]     cap_next;
    stats_upd_t           stats_upd;
    logic [TOTAL_W-1:0]   hit_total;
    logic [TOTAL_W-1:0]   miss_total;

    lkc_ram #(
        .WIDTH (RAM_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (issue_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    lkc_stats u_stats (
        .clk        (clk),
        .rst_n      (rst_n),
        .upd        (stats_upd),
        .hit_total  (hit_total),
        .miss_total (miss_total)
    );

    assign accept      = req.valid && req.ready;
    assign req.ready   = (state_reg == ST_IDLE);
    assign ram_re      = ((state_reg == ST_SCAN) || (state_reg == ST_UPDATE))
                         && (issue_reg < SWP_W'(ENTRIES));
    assign rd_tag      = ram_rdata[RAM_W-1:IDX_W];
    assign rd_rank     = ram_rdata[IDX_W-1:0];
    assign rd_valid    = valid_reg[pend_addr_reg];
    assign sweep_last  = pend_reg && (pend_addr_reg == IDX_W'(ENTRIES - 1));
    assign oldest_rank = IDX_W'(count_reg - CNT_W'(1));
    assign evict_now   = !hit_found_reg && (count_reg >= cap_reg) && (count_reg != '0);
    assign out_load    = (state_reg == ST_FINISH) && (!out_valid_reg || rsp.ready);

    assign cap_raw  = {2'b00, cfg_data};
    assign cap_next = (cap_raw == 9'd0) ? CNT_W'(1) :
                      (cap_raw > 9'(ENTRIES)) ? CNT_W'(ENTRIES) : CNT_W'(cap_raw);

    assign stats_upd.hit_inc  = (state_reg == ST_DECIDE) && hit_found_reg;
    assign stats_upd.miss_inc = (state_reg == ST_DECIDE) && !hit_found_reg;

    // Write port: rank aging during the second sweep, then the target entry.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = pend_addr_reg;
        ram_wdata = {rd_tag, rd_rank + IDX_W'(1)};
        if (state_reg == ST_UPDATE)
        begin
            ram_we = pend_reg && rd_valid && (pend_addr_reg != tgt_reg)
                     && (!hit_reg || (rd_rank < hit_rank_reg));
        end
        else if (state_reg == ST_WRITE)
        begin
            ram_we    = 1'b1;
            ram_waddr = tgt_reg;
            ram_wdata = {key_reg, IDX_W'(0)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            count_reg     <= '0;
            cap_reg       <= CNT_W'((CAP_RESET > ENTRIES) ? ENTRIES : CAP_RESET);
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (count_reg == '0))
            begin
                cap_reg <= cap_next;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            pend_reg <= ram_re;
            if (ram_re)
            begin
                issue_reg <= issue_reg + SWP_W'(1);
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    issue_reg <= '0;
                    if (accept)
                    begin
                        if (req.mode == MODE_CLEAR)
                        begin
                            valid_reg <= '0;
                            count_reg <= '0;
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (sweep_last)
                    begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE:
                begin
                    issue_reg <= '0;
                    if (!hit_found_reg && !evict_now)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE:
                begin
                    if (sweep_last)
                    begin
                        state_reg <= ST_WRITE;
                    end
                end
                ST_WRITE:
                begin
                    valid_reg[tgt_reg] <= 1'b1;
                    state_reg          <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Search results and response payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg        <= KEY_BITS'(req.key);
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            ev_found_reg   <= 1'b0;
            hit_reg        <= 1'b0;
            evict_reg      <= 1'b0;
            tgt_reg        <= '0;
        end
        if ((state_reg == ST_SCAN) && pend_reg)
        begin
            if (rd_valid && (rd_tag == key_reg) && !hit_found_reg)
            begin
                hit_found_reg <= 1'b1;
                hit_slot_reg  <= pend_addr_reg;
                hit_rank_reg  <= rd_rank;
            end
            if (!rd_valid && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_slot_reg  <= pend_addr_reg;
            end
            if (rd_valid && (rd_rank == oldest_rank) && !ev_found_reg)
            begin
                ev_found_reg <= 1'b1;
                ev_slot_reg  <= pend_addr_reg;
                ev_key_reg   <= rd_tag;
            end
        end
        if (state_reg == ST_DECIDE)
        begin
            hit_reg   <= hit_found_reg;
            evict_reg <= evict_now;
            tgt_reg   <= hit_found_reg ? hit_slot_reg :
                         evict_now ? ev_slot_reg : free_slot_reg;
        end
        pend_addr_reg <= issue_reg[IDX_W-1:0];
        if (out_load)
        begin
            rsp.hit         <= hit_reg;
            rsp.slot        <= SLOT_W'(tgt_reg);
            rsp.evicted     <= evict_reg;
            rsp.evicted_key <= evict_reg ? KEY_W'(ev_key_reg) : '0;
            rsp.occupancy   <= OCC_W'(count_reg);
            rsp.hit_total   <= hit_total;
            rsp.miss_total  <= miss_total;
        end
    end

    assign rsp.valid = out_valid_reg;

`ifndef ASSERT_OFF
    a_occ_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= cap_reg))
        else $error("occupancy above capacity");
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !req.ready)
        else $error("second request taken while one is in work");
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.hit) |-> !rsp.evicted)
        else $error("hit response reports an eviction");
`endif

endmodule

`default_nettype wire
